[hw/rtl/best_fit_range_allocator_assert.svh]
// assertion macros for the best fit range allocator checker
`ifndef BEST_FIT_RANGE_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_RANGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BFRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication, disabled while reset is low
`define BFRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

[hw/rtl/bfra_pkg.sv]
// shared types, constants and helpers of the best fit range allocator
package bfra_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LEN_W   = 33;
  localparam int unsigned SUM_W   = 35;
  localparam int unsigned PADDR_W = 3;

  localparam logic [LEN_W-1:0]  LEN_MAX        = {LEN_W{1'b1}};
  localparam logic [DATA_W-1:0] POOL_SIZE_RST  = 32'd65536;

  // register index, taken from the word address bit of paddr
  localparam logic REG_POOL_SIZE = 1'b0;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_FIT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  // compare results for one table entry
  typedef struct packed {
    logic fits;
    logic exact;
    logic worse;
    logic next_hit;
    logic prev_hit;
  } scan_flags_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [SUM_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v > {{(SUM_W-LEN_W){1'b0}}, LEN_MAX}) begin
      r = LEN_MAX;
    end else begin
      r = v[LEN_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/bfra_table.sv]
// free range table: start and length memories with one write and one read port
module bfra_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_i,
  input  logic [bfra_pkg::DATA_W-1:0]  pool_size_i,
  input  logic                         wr_en_i,
  input  logic [IDX_W-1:0]             wr_idx_i,
  input  logic [bfra_pkg::DATA_W-1:0]  wr_start_i,
  input  logic [bfra_pkg::LEN_W-1:0]   wr_len_i,
  input  logic                         rd_en_i,
  input  logic [IDX_W-1:0]             rd_idx_i,
  output logic [bfra_pkg::DATA_W-1:0]  rd_start_o,
  output logic [bfra_pkg::LEN_W-1:0]   rd_len_o
);
  import bfra_pkg::*;

  logic [DATA_W-1:0] start_mem [DEPTH];
  logic [LEN_W-1:0]  len_mem   [DEPTH];

  logic [DATA_W-1:0] rd_start_q;
  logic [LEN_W-1:0]  rd_len_q;
  logic              e0_valid_q;
  logic              rd_zero_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      start_mem[wr_idx_i] <= wr_start_i;
      len_mem[wr_idx_i]   <= wr_len_i;
    end
    if (rd_en_i) begin
      rd_start_q <= start_mem[rd_idx_i];
      rd_len_q   <= len_mem[rd_idx_i];
    end
  end

  // entry 0 reads as the whole pool until the block writes it, and again after a clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_valid_q <= 1'b0;
      rd_zero_q  <= 1'b0;
    end else begin
      if (clr_i) begin
        e0_valid_q <= 1'b0;
      end else if (wr_en_i && (wr_idx_i == '0)) begin
        e0_valid_q <= 1'b1;
      end
      if (rd_en_i) begin
        rd_zero_q <= (rd_idx_i == '0) && !e0_valid_q;
      end
    end
  end

  assign rd_start_o = rd_zero_q ? '0 : rd_start_q;
  assign rd_len_o   = rd_zero_q ? {1'b0, pool_size_i} : rd_len_q;

endmodule

[hw/rtl/bfra_scan_unit.sv]
// shared compare unit applied to one table entry per cycle
module bfra_scan_unit (
  input  logic [bfra_pkg::DATA_W-1:0] entry_start_i,
  input  logic [bfra_pkg::LEN_W-1:0]  entry_len_i,
  input  logic [bfra_pkg::DATA_W-1:0] count_i,
  input  logic [bfra_pkg::DATA_W-1:0] first_i,
  input  logic [bfra_pkg::LEN_W-1:0]  end_i,
  input  logic                        best_v_i,
  input  logic [bfra_pkg::LEN_W-1:0]  best_len_i,
  output bfra_pkg::scan_flags_t       flags_o
);
  import bfra_pkg::*;

  logic [LEN_W-1:0] count_ext;
  logic [LEN_W:0]   entry_end;

  assign count_ext = {1'b0, count_i};
  // exact end of the entry, never wraps
  assign entry_end = {2'b00, entry_start_i} + {1'b0, entry_len_i};

  always_comb begin
    flags_o.fits     = entry_len_i >= count_ext;
    flags_o.exact    = entry_len_i == count_ext;
    flags_o.worse    = best_v_i && (best_len_i < entry_len_i);
    flags_o.next_hit = {1'b0, entry_start_i} == end_i;
    flags_o.prev_hit = entry_end == {2'b00, first_i};
  end

endmodule

[hw/rtl/best_fit_range_allocator.sv]
// top level of the best fit range allocator with coalescing free
//
//  channel    signals                                    handshake
//  request    start, opcode_i, request_count_i,          taken when start && !busy
//             free_start_i
//  result     done_o, status_o, alloc_start_o            one-cycle strobe, no stall
//  config     psel, penable, pwrite, paddr, pwdata,      write on psel&penable&pwrite,
//             prdata, pready                             pready tied high
//
// a request with a nonzero count scans the table one entry per cycle through the single
// read port of the table memory: an issue step, then ST_SCAN over the entries
// (at most total_q of them, fewer on an exact fit or when both neighbors are found),
// then ST_DECIDE, then ST_MOVE_WR when an exact fit removes an entry, or ST_MOVE_RD
// and ST_MOVE_WR when a free joins both neighbors
// a zero count, or an allocate on an empty table, answers in the next cycle
// reset leaves pool_size at 65536 and the table as one whole-pool entry, no clearing pass
// the result word is shown for exactly one cycle with done_o; busy is low in that cycle
module best_fit_range_allocator #(
  parameter int unsigned MAX_FREE_BLOCKS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode_i,
  input  logic [bfra_pkg::DATA_W-1:0]         request_count_i,
  input  logic [bfra_pkg::DATA_W-1:0]         free_start_i,
  // result
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic [bfra_pkg::DATA_W-1:0]         alloc_start_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bfra_pkg::PADDR_W-1:0]        paddr,
  input  logic [bfra_pkg::DATA_W-1:0]         pwdata,
  output logic [bfra_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import bfra_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_FREE_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_FREE_BLOCKS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FREE_BLOCKS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MOVE_RD,
    ST_MOVE_WR
  } state_e;

  state_e            state_q, state_d;

  // request word
  logic              op_q, op_d;
  logic [DATA_W-1:0] count_q, count_d;
  logic [DATA_W-1:0] first_q, first_d;
  logic [LEN_W-1:0]  end_q, end_d;

  // table bookkeeping
  logic [CNT_W-1:0]  total_q, total_d;
  logic [DATA_W-1:0] pool_size_q, pool_size_d;
  logic [IDX_W-1:0]  scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0]  move_dst_q, move_dst_d;

  // best fit candidate
  logic              best_v_q, best_v_d;
  logic              best_exact_q, best_exact_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [DATA_W-1:0] best_start_q, best_start_d;
  logic [LEN_W-1:0]  best_len_q, best_len_d;

  // merge neighbors
  logic              prev_v_q, prev_v_d;
  logic [IDX_W-1:0]  prev_idx_q, prev_idx_d;
  logic [DATA_W-1:0] prev_start_q, prev_start_d;
  logic [LEN_W-1:0]  prev_len_q, prev_len_d;
  logic              next_v_q, next_v_d;
  logic [IDX_W-1:0]  next_idx_q, next_idx_d;
  logic [LEN_W-1:0]  next_len_q, next_len_d;

  // result word
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] alloc_start_q, alloc_start_d;

  // table ports
  logic              tbl_clr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [DATA_W-1:0] wr_start;
  logic [LEN_W-1:0]  wr_len;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] rd_start;
  logic [LEN_W-1:0]  rd_len;

  scan_flags_t       flags;

  logic              accept;
  logic              cfg_wr;
  logic              scan_last;
  logic              scan_stop;
  logic [IDX_W-1:0]  last_idx;
  logic [SUM_W-1:0]  sum_both;
  logic [SUM_W-1:0]  sum_prev;
  logic [SUM_W-1:0]  sum_next;

  assign busy    = state_q != ST_IDLE;
  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_SIZE);
  assign prdata  = (paddr[2] == REG_POOL_SIZE) ? pool_size_q : '0;
  assign tbl_clr = cfg_wr;

  assign last_idx  = IDX_W'(total_q - ONE_CNT);
  assign scan_last = (CNT_W'(scan_idx_q) + ONE_CNT) == total_q;

  // merged lengths, saturated at the 33-bit ceiling
  assign sum_both = {2'b00, prev_len_q} + {3'b000, count_q} + {2'b00, next_len_q};
  assign sum_prev = {2'b00, prev_len_q} + {3'b000, count_q};
  assign sum_next = {2'b00, next_len_q} + {3'b000, count_q};

  bfra_table #(
    .DEPTH (MAX_FREE_BLOCKS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (tbl_clr),
    .pool_size_i (pool_size_q),
    .wr_en_i     (wr_en),
    .wr_idx_i    (wr_idx),
    .wr_start_i  (wr_start),
    .wr_len_i    (wr_len),
    .rd_en_i     (rd_en),
    .rd_idx_i    (rd_idx),
    .rd_start_o  (rd_start),
    .rd_len_o    (rd_len)
  );

  bfra_scan_unit u_scan (
    .entry_start_i (rd_start),
    .entry_len_i   (rd_len),
    .count_i       (count_q),
    .first_i       (first_q),
    .end_i         (end_q),
    .best_v_i      (best_v_q),
    .best_len_i    (best_len_q),
    .flags_o       (flags)
  );

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    count_d       = count_q;
    first_d       = first_q;
    end_d         = end_q;
    total_d       = total_q;
    pool_size_d   = pool_size_q;
    scan_idx_d    = scan_idx_q;
    move_dst_d    = move_dst_q;
    best_v_d      = best_v_q;
    best_exact_d  = best_exact_q;
    best_idx_d    = best_idx_q;
    best_start_d  = best_start_q;
    best_len_d    = best_len_q;
    prev_v_d      = prev_v_q;
    prev_idx_d    = prev_idx_q;
    prev_start_d  = prev_start_q;
    prev_len_d    = prev_len_q;
    next_v_d      = next_v_q;
    next_idx_d    = next_idx_q;
    next_len_d    = next_len_q;
    done_d        = 1'b0;
    status_d      = status_q;
    alloc_start_d = alloc_start_q;
    wr_en         = 1'b0;
    wr_idx        = '0;
    wr_start      = '0;
    wr_len        = '0;
    rd_en         = 1'b0;
    rd_idx        = '0;
    scan_stop     = 1'b0;

    // pool size write rebuilds the table as one whole-pool entry
    if (cfg_wr) begin
      pool_size_d = pwdata;
      total_d     = ONE_CNT;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = opcode_i;
          count_d  = request_count_i;
          first_d  = free_start_i;
          end_d    = {1'b0, free_start_i} + {1'b0, request_count_i};
          best_v_d = 1'b0;
          prev_v_d = 1'b0;
          next_v_d = 1'b0;
          if (request_count_i == '0) begin
            done_d        = 1'b1;
            status_d      = STATUS_OK;
            alloc_start_d = '0;
          end else if (total_q == '0) begin
            if (opcode_i == OP_ALLOC) begin
              done_d        = 1'b1;
              status_d      = STATUS_NO_FIT;
              alloc_start_d = '0;
            end else begin
              state_d = ST_DECIDE;
            end
          end else begin
            rd_en      = 1'b1;
            rd_idx     = '0;
            scan_idx_d = '0;
            state_d    = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (op_q == OP_ALLOC) begin
          // smallest fit wins, later wins a tie, exact fit ends the scan
          if (flags.fits && !flags.worse) begin
            best_v_d     = 1'b1;
            best_exact_d = flags.exact;
            best_idx_d   = scan_idx_q;
            best_start_d = rd_start;
            best_len_d   = rd_len;
            scan_stop    = flags.exact;
          end
        end else begin
          if (flags.next_hit) begin
            next_v_d   = 1'b1;
            next_idx_d = scan_idx_q;
            next_len_d = rd_len;
            if (prev_v_q) begin
              scan_stop = 1'b1;
            end
          end
          if (flags.prev_hit && !(flags.next_hit && prev_v_q)) begin
            prev_v_d     = 1'b1;
            prev_idx_d   = scan_idx_q;
            prev_start_d = rd_start;
            prev_len_d   = rd_len;
            if (next_v_q || flags.next_hit) begin
              scan_stop = 1'b1;
            end
          end
        end
        if (scan_stop || scan_last) begin
          state_d = ST_DECIDE;
        end else begin
          rd_en      = 1'b1;
          rd_idx     = scan_idx_q + IDX_W'(1);
          scan_idx_d = scan_idx_q + IDX_W'(1);
        end
      end

      ST_DECIDE: begin
        if (op_q == OP_ALLOC) begin
          if (!best_v_q) begin
            done_d        = 1'b1;
            status_d      = STATUS_NO_FIT;
            alloc_start_d = '0;
            state_d       = ST_IDLE;
          end else if (best_exact_q) begin
            // exact fit: last entry moves into the winner's slot
            move_dst_d = best_idx_q;
            rd_en      = 1'b1;
            rd_idx     = last_idx;
            state_d    = ST_MOVE_WR;
          end else begin
            wr_en         = 1'b1;
            wr_idx        = best_idx_q;
            wr_start      = best_start_q + count_q;
            wr_len        = best_len_q - {1'b0, count_q};
            done_d        = 1'b1;
            status_d      = STATUS_OK;
            alloc_start_d = best_start_q;
            state_d       = ST_IDLE;
          end
        end else begin
          if (prev_v_q && next_v_q) begin
            // grow prev over both, then fill next's slot from the last entry
            wr_en      = 1'b1;
            wr_idx     = prev_idx_q;
            wr_start   = prev_start_q;
            wr_len     = sat_len(sum_both);
            move_dst_d = next_idx_q;
            state_d    = ST_MOVE_RD;
          end else if (prev_v_q) begin
            wr_en         = 1'b1;
            wr_idx        = prev_idx_q;
            wr_start      = prev_start_q;
            wr_len        = sat_len(sum_prev);
            done_d        = 1'b1;
            status_d      = STATUS_OK;
            alloc_start_d = '0;
            state_d       = ST_IDLE;
          end else if (next_v_q) begin
            wr_en         = 1'b1;
            wr_idx        = next_idx_q;
            wr_start      = first_q;
            wr_len        = sat_len(sum_next);
            done_d        = 1'b1;
            status_d      = STATUS_OK;
            alloc_start_d = '0;
            state_d       = ST_IDLE;
          end else if (total_q >= MAX_CNT) begin
            done_d        = 1'b1;
            status_d      = STATUS_FULL;
            alloc_start_d = '0;
            state_d       = ST_IDLE;
          end else begin
            // no neighbor: append
            wr_en         = 1'b1;
            wr_idx        = IDX_W'(total_q);
            wr_start      = first_q;
            wr_len        = {1'b0, count_q};
            total_d       = total_q + ONE_CNT;
            done_d        = 1'b1;
            status_d      = STATUS_OK;
            alloc_start_d = '0;
            state_d       = ST_IDLE;
          end
        end
      end

      ST_MOVE_RD: begin
        // read the last entry after the prev write has landed
        rd_en   = 1'b1;
        rd_idx  = last_idx;
        state_d = ST_MOVE_WR;
      end

      ST_MOVE_WR: begin
        wr_en         = 1'b1;
        wr_idx        = move_dst_q;
        wr_start      = rd_start;
        wr_len        = rd_len;
        total_d       = total_q - ONE_CNT;
        done_d        = 1'b1;
        status_d      = STATUS_OK;
        alloc_start_d = (op_q == OP_ALLOC) ? best_start_q : '0;
        state_d       = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= OP_ALLOC;
      count_q       <= '0;
      first_q       <= '0;
      end_q         <= '0;
      total_q       <= ONE_CNT;
      pool_size_q   <= POOL_SIZE_RST;
      scan_idx_q    <= '0;
      move_dst_q    <= '0;
      best_v_q      <= 1'b0;
      best_exact_q  <= 1'b0;
      best_idx_q    <= '0;
      best_start_q  <= '0;
      best_len_q    <= '0;
      prev_v_q      <= 1'b0;
      prev_idx_q    <= '0;
      prev_start_q  <= '0;
      prev_len_q    <= '0;
      next_v_q      <= 1'b0;
      next_idx_q    <= '0;
      next_len_q    <= '0;
      done_q        <= 1'b0;
      status_q      <= STATUS_OK;
      alloc_start_q <= '0;
    end else begin
      state_q       <= state_d;
      op_q          <= op_d;
      count_q       <= count_d;
      first_q       <= first_d;
      end_q         <= end_d;
      total_q       <= total_d;
      pool_size_q   <= pool_size_d;
      scan_idx_q    <= scan_idx_d;
      move_dst_q    <= move_dst_d;
      best_v_q      <= best_v_d;
      best_exact_q  <= best_exact_d;
      best_idx_q    <= best_idx_d;
      best_start_q  <= best_start_d;
      best_len_q    <= best_len_d;
      prev_v_q      <= prev_v_d;
      prev_idx_q    <= prev_idx_d;
      prev_start_q  <= prev_start_d;
      prev_len_q    <= prev_len_d;
      next_v_q      <= next_v_d;
      next_idx_q    <= next_idx_d;
      next_len_q    <= next_len_d;
      done_q        <= done_d;
      status_q      <= status_d;
      alloc_start_q <= alloc_start_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign alloc_start_o = alloc_start_q;

endmodule

[hw/rtl/bfra_checker.sv]
// port-level checker for the best fit range allocator and its bind
`include "best_fit_range_allocator_assert.svh"

module bfra_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [1:0]                  status_o,
  input logic [bfra_pkg::DATA_W-1:0] alloc_start_o
);
  import bfra_pkg::*;

  logic accept;
  logic status_legal;

  assign accept       = start && !busy;
  assign status_legal = (status_o == STATUS_OK) || (status_o == STATUS_NO_FIT) ||
                        (status_o == STATUS_FULL);

  // an accepted word either answers at once or keeps the block busy
  `BFRA_ASSERT_NXT(a_accept_progress, clk_i, rst_ni, accept, busy || done_o)

  // the block only leaves busy by delivering a result
  `BFRA_ASSERT_IMP(a_busy_ends_done, clk_i, rst_ni, $fell(busy), done_o)

  // a nonzero start only comes with a successful allocation
  `BFRA_ASSERT_IMP(a_start_needs_ok, clk_i, rst_ni, done_o && (alloc_start_o != '0),
                   status_o == STATUS_OK)

  // every delivered status is a defined code
  `BFRA_ASSERT_IMP(a_status_legal, clk_i, rst_ni, done_o, status_legal)

endmodule

bind best_fit_range_allocator bfra_checker u_bfra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .alloc_start_o (alloc_start_o)
);
